>>> design/kbde_pkg.sv
package kbde_pkg;

	// Build-time sizes of the engine.
	localparam int RING_DEPTH = 8;
	localparam int KEY_COUNT  = 256;
	localparam int SEQ_BITS   = 16;

	localparam int NWORDS   = KEY_COUNT / 64;
	localparam int WORD_AW  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int START_W  = $clog2(RING_DEPTH + 1);
	localparam int LOST_W   = 15;
	localparam int LOST_MAX = 32767;
	localparam int BIT_AW   = 6;

	// Field widths of the stream words.
	localparam int SEQ_W    = 16;
	localparam int IDX_W    = 3;
	localparam int USAGE_W  = 8;
	localparam int WIDX_W   = 2;
	localparam int KEYS_W   = 64;
	localparam int CODE_W   = 8;
	localparam int IN_DW    = 96;
	localparam int OUT_DW   = 24;

	typedef enum logic [1:0] {
		CMD_HEADER  = 2'd0,
		CMD_ENTRY   = 2'd1,
		CMD_WORD    = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic {
		KIND_KEY  = 1'b0,
		KIND_LOSS = 1'b1
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Result of the sequence gap evaluation for one header.
	typedef struct packed {
		logic [START_W-1:0] replay_start;
		logic [LOST_W-1:0]  lost;
	} gap_t;

endpackage

>>> design/kbde_gap.sv
module kbde_gap (
	input  logic [kbde_pkg::SEQ_BITS-1:0] seq,
	input  logic [kbde_pkg::SEQ_BITS-1:0] last_seq,
	input  logic                          have_baseline,
	output kbde_pkg::gap_t                gap
);

	logic [kbde_pkg::SEQ_BITS-1:0] raw;
	logic [kbde_pkg::SEQ_BITS-1:0] over;

	assign raw  = seq - last_seq;
	assign over = raw - kbde_pkg::SEQ_BITS'(kbde_pkg::RING_DEPTH);

	// A raw distance with the top bit set reads as a negative gap: stale header.
	always_comb begin
		gap.replay_start = kbde_pkg::START_W'(kbde_pkg::RING_DEPTH);
		gap.lost         = '0;
		priority if (!have_baseline || raw == '0 || raw[kbde_pkg::SEQ_BITS-1]) begin
			gap.replay_start = kbde_pkg::START_W'(kbde_pkg::RING_DEPTH);
		end else if (32'(raw) <= kbde_pkg::RING_DEPTH) begin
			gap.replay_start = kbde_pkg::START_W'(kbde_pkg::RING_DEPTH)
				- kbde_pkg::START_W'(raw);
		end else begin
			gap.replay_start = '0;
			if (32'(over) > kbde_pkg::LOST_MAX) begin
				gap.lost = kbde_pkg::LOST_W'(kbde_pkg::LOST_MAX);
			end else begin
				gap.lost = kbde_pkg::LOST_W'(over);
			end
		end
	end

endmodule

>>> design/keyboard_bitmap_diff_engine_top.sv
// Keyboard bitmap diff engine.
// The slave channel takes one command word per handshake: a snapshot header, a ring
// entry, a bitmap word or a release word, selected by s_tuser. The master channel
// returns result words: key press and release events (m_tuser low) or a loss report
// (m_tuser high), with m_tlast on the final word caused by one input word.
// A header always gives one loss report, in the cycle after acceptance; it also sets the
// window of ring slots that later ring entries replay into the held-key shadow.
// A ring entry with nonzero usage inside that window gives one key event, in the cycle after acceptance.
// A bitmap or release word is compared with the shadow and the difference is walked
// by a one-bit-per-cycle scanner, lowest key first, starting the cycle after acceptance.
// The scan stops right after the highest differing bit; s_tready stays low while a word
// is scanned, and the next word can be taken once the scanner is back in idle.
// Its events leave through the output register, at most one per cycle;
// a word that differs nowhere gives no result and the block is ready the next cycle.
// When the receiver stalls, the pending result word holds in the output register,
// s_tready stays low, and the scanner waits on each set bit until that register can be
// refilled; clear bits are still skipped during a stall.
// After reset the shadow is all released, no sequence baseline exists, and no ring
// slot is in the replay window until the first header arrives.
module keyboard_bitmap_diff_engine_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// seq[15:0], entry_index[18:16], usage[26:19], down[27], word_index[29:28],
	// key_bits[93:30], zero pad[95:94]
	input  logic [kbde_pkg::IN_DW-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [1:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// code[7:0], pressed[8], lost_count[23:9]
	output logic [kbde_pkg::OUT_DW-1:0] m_tdata,
	// kind[0]
	output logic                        m_tuser,
	output logic                        m_tlast
);

	// Input field unpacking.
	logic [kbde_pkg::SEQ_W-1:0]   in_seq;
	logic [kbde_pkg::IDX_W-1:0]   in_entry_index;
	logic [kbde_pkg::USAGE_W-1:0] in_usage;
	logic                         in_down;
	logic [kbde_pkg::WIDX_W-1:0]  in_word_index;
	logic [kbde_pkg::KEYS_W-1:0]  in_key_bits;
	kbde_pkg::cmd_t               in_cmd;

	assign in_seq         = s_tdata[15:0];
	assign in_entry_index = s_tdata[18:16];
	assign in_usage       = s_tdata[26:19];
	assign in_down        = s_tdata[27];
	assign in_word_index  = s_tdata[29:28];
	assign in_key_bits    = s_tdata[93:30];
	assign in_cmd         = kbde_pkg::cmd_t'(s_tuser);

	// Architectural state.
	logic [kbde_pkg::KEYS_W-1:0]   held_q [kbde_pkg::NWORDS];
	logic [kbde_pkg::SEQ_BITS-1:0] last_seq_q;
	logic                          baseline_q;
	logic [kbde_pkg::START_W-1:0]  replay_start_q;

	// Scanner state.
	kbde_pkg::state_t             state_q, state_d;
	logic [kbde_pkg::KEYS_W-1:0]  diff_q;
	logic [kbde_pkg::KEYS_W-1:0]  bits_q;
	logic [kbde_pkg::BIT_AW-1:0]  cnt_q;
	logic [kbde_pkg::WIDX_W-1:0]  word_q;

	// Output register.
	logic                         out_valid_q;
	logic                         out_kind_q;
	logic [kbde_pkg::CODE_W-1:0]  out_code_q;
	logic                         out_pressed_q;
	logic [kbde_pkg::LOST_W-1:0]  out_lost_q;
	logic                         out_last_q;

	logic slot_free;
	logic accept;
	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == kbde_pkg::ST_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;

	// One read port on the shadow: ring entries address by usage, words by index.
	logic [kbde_pkg::WIDX_W-1:0]  rd_word;
	logic [kbde_pkg::WORD_AW-1:0] rd_addr;
	logic                         rd_in_range;
	logic [kbde_pkg::KEYS_W-1:0]  rd_data;
	logic [kbde_pkg::KEYS_W-1:0]  key_mask;

	assign rd_word     = (in_cmd == kbde_pkg::CMD_ENTRY) ? in_usage[7:6] : in_word_index;
	assign rd_addr     = kbde_pkg::WORD_AW'(rd_word);
	assign rd_in_range = 32'(rd_word) < kbde_pkg::NWORDS;
	assign rd_data     = held_q[rd_addr];
	assign key_mask    = kbde_pkg::KEYS_W'(1) << in_usage[5:0];

	kbde_pkg::gap_t gap;

	kbde_gap u_gap (
		.seq           (kbde_pkg::SEQ_BITS'(in_seq)),
		.last_seq      (last_seq_q),
		.have_baseline (baseline_q),
		.gap           (gap)
	);

	// Next state, emitted result and shadow update.
	logic                         emit;
	logic                         emit_kind;
	logic [kbde_pkg::CODE_W-1:0]  emit_code;
	logic                         emit_pressed;
	logic [kbde_pkg::LOST_W-1:0]  emit_lost;
	logic                         emit_last;
	logic                         held_we;
	logic [kbde_pkg::KEYS_W-1:0]  held_wdata;
	logic                         load_scan;
	logic                         scan_step;
	logic                         hdr_take;
	logic [kbde_pkg::KEYS_W-1:0]  new_bits;
	logic [kbde_pkg::KEYS_W-1:0]  new_diff;
	logic                         entry_hit;

	always_comb begin
		state_d      = state_q;
		emit         = 1'b0;
		emit_kind    = kbde_pkg::KIND_KEY;
		emit_code    = '0;
		emit_pressed = 1'b0;
		emit_lost    = '0;
		emit_last    = 1'b0;
		held_we      = 1'b0;
		held_wdata   = rd_data;
		load_scan    = 1'b0;
		scan_step    = 1'b0;
		hdr_take     = 1'b0;
		new_bits     = (in_cmd == kbde_pkg::CMD_RELEASE) ? '0 : in_key_bits;
		new_diff     = (in_cmd == kbde_pkg::CMD_RELEASE) ? rd_data : (rd_data ^ in_key_bits);
		entry_hit    = (32'(in_entry_index) >= 32'(replay_start_q))
			&& (32'(in_entry_index) < kbde_pkg::RING_DEPTH) && (in_usage != '0);
		unique case (state_q)
			kbde_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						kbde_pkg::CMD_HEADER: begin
							hdr_take  = 1'b1;
							emit      = 1'b1;
							emit_kind = kbde_pkg::KIND_LOSS;
							emit_lost = gap.lost;
							emit_last = 1'b1;
						end
						kbde_pkg::CMD_ENTRY: begin
							if (entry_hit) begin
								emit         = 1'b1;
								emit_code    = in_usage;
								emit_pressed = in_down;
								emit_last    = 1'b1;
								held_we      = rd_in_range;
								held_wdata   = in_down ? (rd_data | key_mask)
									: (rd_data & ~key_mask);
							end
						end
						kbde_pkg::CMD_WORD, kbde_pkg::CMD_RELEASE: begin
							if (rd_in_range) begin
								held_we    = 1'b1;
								held_wdata = new_bits;
								if (new_diff != '0) begin
									load_scan = 1'b1;
									state_d   = kbde_pkg::ST_SCAN;
								end
							end
						end
						default: ;
					endcase
				end
			end
			kbde_pkg::ST_SCAN: begin
				// Clear bits move on at once; a set bit waits for the output register.
				if (!diff_q[0] || slot_free) begin
					scan_step = 1'b1;
					if (diff_q[0]) begin
						emit         = 1'b1;
						emit_code    = {word_q, cnt_q};
						emit_pressed = bits_q[0];
						emit_last    = (diff_q[kbde_pkg::KEYS_W-1:1] == '0);
					end
					if (diff_q[kbde_pkg::KEYS_W-1:1] == '0) begin
						state_d = kbde_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = kbde_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= kbde_pkg::ST_IDLE;
			last_seq_q     <= '0;
			baseline_q     <= 1'b0;
			replay_start_q <= kbde_pkg::START_W'(kbde_pkg::RING_DEPTH);
			out_valid_q    <= 1'b0;
			for (int i = 0; i < kbde_pkg::NWORDS; i++) begin
				held_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (hdr_take) begin
				last_seq_q     <= kbde_pkg::SEQ_BITS'(in_seq);
				baseline_q     <= 1'b1;
				replay_start_q <= gap.replay_start;
			end
			if (held_we) begin
				held_q[rd_addr] <= held_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q    <= emit_kind;
			out_code_q    <= emit_code;
			out_pressed_q <= emit_pressed;
			out_lost_q    <= emit_lost;
			out_last_q    <= emit_last;
		end
		if (load_scan) begin
			diff_q <= new_diff;
			bits_q <= new_bits;
			cnt_q  <= '0;
			word_q <= in_word_index;
		end else if (scan_step) begin
			diff_q <= diff_q >> 1;
			bits_q <= bits_q >> 1;
			cnt_q  <= cnt_q + kbde_pkg::BIT_AW'(1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_lost_q, out_pressed_q, out_code_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// While scanning, the output register only ever carries key events.
	a_scan_keys_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kbde_pkg::ST_SCAN && m_tvalid) |-> !m_tuser)
		else $error("loss report seen during a bitmap scan");

	// The scan always finishes by the top bit of the word.
	a_scan_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kbde_pkg::ST_SCAN && cnt_q == '1) |-> (diff_q[kbde_pkg::KEYS_W-1:1] == '0))
		else $error("bit scanner ran past the end of the word");

	// A scan holds at least one set bit whenever it still has work.
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kbde_pkg::ST_SCAN) |-> (diff_q != '0))
		else $error("bit scanner active with nothing left to report");

	// Emitting the final word of a scan returns the block to idle.
	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kbde_pkg::ST_SCAN && emit && emit_last) |=> (state_q == kbde_pkg::ST_IDLE))
		else $error("scan continued after its last event");
`endif

endmodule
